>>> sv/pms_pkg.sv
// Package for the parking maneuver sequencer: request, result, configuration
// and state types, mode and drive codes, and fixed maneuver constants.
// No dependencies.
package pms_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FRONT_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REAR_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_CM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_TOL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_MAX = 3'd5;

  localparam logic [3:0] MODE_WAIT     = 4'd0;
  localparam logic [3:0] MODE_SEARCH   = 4'd1;
  localparam logic [3:0] MODE_RETURN   = 4'd2;
  localparam logic [3:0] MODE_TAIL     = 4'd3;
  localparam logic [3:0] MODE_REVERSE  = 4'd4;
  localparam logic [3:0] MODE_NOSEIN   = 4'd5;
  localparam logic [3:0] MODE_STRAIGHT = 4'd6;
  localparam logic [3:0] MODE_PARKED   = 4'd7;
  localparam logic [3:0] MODE_OBSTACLE = 4'd8;
  localparam logic [3:0] MODE_CENTER   = 4'd9;

  localparam logic [2:0] DRV_STOP      = 3'd0;
  localparam logic [2:0] DRV_FWD       = 3'd1;
  localparam logic [2:0] DRV_REV       = 3'd2;
  localparam logic [2:0] DRV_TAIL      = 3'd3;
  localparam logic [2:0] DRV_STRAIGHT  = 3'd4;
  localparam logic [2:0] DRV_NOSEIN    = 3'd5;
  localparam logic [2:0] DRV_FWDPULSE  = 3'd6;
  localparam logic [2:0] DRV_REVPULSE  = 3'd7;

  localparam logic [7:0] RETURN_TICKS  = 8'd4;
  localparam logic [2:0] TURN_MAX      = 3'd6;
  localparam logic [2:0] TURN_MIN      = 3'd5;
  localparam logic [9:0] LATERAL_BASE  = 10'd10;
  localparam logic [1:0] EXTRA_MAX     = 2'd2;
  localparam logic [7:0] SHORT_MIN     = 8'd3;

  typedef struct packed {
    logic [9:0] left_cm;
    logic [9:0] right_cm;
    logic [9:0] front_cm;
    logic [9:0] rear_cm;
    logic       start_pressed;
    logic       reset_pressed;
  } pms_req_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [2:0]  drive;
    logic        side_right;
    logic [15:0] gap_len;
  } pms_res_t;

  typedef struct packed {
    logic [9:0] front_min_cm;
    logic [9:0] rear_min_cm;
    logic [9:0] gap_cm;
    logic [7:0] gap_min_ticks;
    logic [5:0] center_tol_cm;
    logic [7:0] center_max_steps;
  } pms_cfg_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] left_cnt;
    logic [15:0] right_cnt;
    logic [15:0] gap_ticks;
    logic [9:0]  lateral_cm;
    logic [7:0]  man_timer;
    logic [7:0]  safety_timer;
    logic [7:0]  turn_done;
    logic [7:0]  center_steps;
    logic        side;
  } pms_state_t;

endpackage

>>> sv/pms_step.sv
// Next-state and drive logic of the parking sequencer for one request.
// Depends on pms_pkg.
module pms_step (
  input  pms_pkg::pms_state_t state_i,
  input  pms_pkg::pms_cfg_t   cfg_i,
  input  pms_pkg::pms_req_t   req_i,
  output pms_pkg::pms_state_t state_o,
  output pms_pkg::pms_res_t   res_o
);
  import pms_pkg::*;

  function automatic logic [7:0] inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [2:0] turn_limit(input logic [15:0] g);
    return (g[15:1] >= 15'(TURN_MAX)) ? TURN_MAX : TURN_MIN;
  endfunction

  pms_state_t nxt;
  logic [2:0]  drive;
  logic        left_far;
  logic        right_far;
  logic        left_take;
  logic [7:0]  tick;
  logic [9:0]  lat_diff;
  logic [8:0]  lat_half;
  logic [1:0]  extra;
  logic [3:0]  rev_limit;
  logic [7:0]  straight_lim;
  logic [10:0] pair_sum;
  logic [9:0]  avg;
  logic [9:0]  err_f;
  logic [9:0]  err_r;
  logic [9:0]  tol;
  logic [10:0] avg_tol;
  logic [7:0]  steps;

  assign left_far  = (req_i.left_cm > cfg_i.gap_cm) || (req_i.left_cm == 10'd0);
  assign right_far = (req_i.right_cm > cfg_i.gap_cm) || (req_i.right_cm == 10'd0);

  assign lat_diff  = state_i.lateral_cm - LATERAL_BASE;
  assign lat_half  = lat_diff[9:1];
  assign extra     = (state_i.lateral_cm <= LATERAL_BASE) ? 2'd0 :
                     (lat_half >= 9'(EXTRA_MAX)) ? EXTRA_MAX : lat_half[1:0];
  assign rev_limit = {1'b0, turn_limit(state_i.gap_ticks)} + {2'b00, extra};

  assign straight_lim = (state_i.turn_done >= SHORT_MIN + 8'd2) ?
                        state_i.turn_done - 8'd2 : SHORT_MIN;

  assign pair_sum = {1'b0, req_i.front_cm} + {1'b0, req_i.rear_cm};
  assign avg      = pair_sum[10:1];
  assign err_f    = (req_i.front_cm > avg) ? req_i.front_cm - avg : avg - req_i.front_cm;
  assign err_r    = (req_i.rear_cm > avg) ? req_i.rear_cm - avg : avg - req_i.rear_cm;
  assign tol      = {4'b0000, cfg_i.center_tol_cm};
  assign avg_tol  = {1'b0, avg} + {1'b0, tol};

  always_comb begin
    nxt       = state_i;
    drive     = DRV_STOP;
    left_take = 1'b0;
    tick      = 8'd0;
    steps     = 8'd0;

    if (req_i.reset_pressed) begin
      nxt.mode         = MODE_WAIT;
      nxt.left_cnt     = 16'd0;
      nxt.right_cnt    = 16'd0;
      nxt.safety_timer = 8'd0;
    end

    case (nxt.mode)
      MODE_WAIT: begin
        if (req_i.start_pressed) begin
          nxt.left_cnt  = 16'd0;
          nxt.right_cnt = 16'd0;
          nxt.mode      = MODE_SEARCH;
        end
      end
      MODE_SEARCH: begin
        drive = DRV_FWD;
        if ((req_i.front_cm != 10'd0) && (req_i.front_cm < cfg_i.front_min_cm)) begin
          nxt.mode = MODE_OBSTACLE;
        end
        if (left_far) begin
          nxt.left_cnt = inc16(nxt.left_cnt);
        end else if (nxt.left_cnt > {8'd0, cfg_i.gap_min_ticks}) begin
          left_take        = 1'b1;
          nxt.side         = 1'b0;
          drive            = DRV_STOP;
          nxt.gap_ticks    = nxt.left_cnt;
          nxt.lateral_cm   = req_i.left_cm;
          nxt.man_timer    = 8'd0;
          nxt.safety_timer = 8'd0;
          nxt.mode         = MODE_RETURN;
        end else begin
          nxt.left_cnt = 16'd0;
        end
        if (!left_take) begin
          if (right_far) begin
            nxt.right_cnt = inc16(nxt.right_cnt);
          end else if (nxt.right_cnt > {8'd0, cfg_i.gap_min_ticks}) begin
            nxt.side         = 1'b1;
            drive            = DRV_STOP;
            nxt.gap_ticks    = nxt.right_cnt;
            nxt.lateral_cm   = req_i.right_cm;
            nxt.man_timer    = 8'd0;
            nxt.safety_timer = 8'd0;
            nxt.mode         = MODE_RETURN;
          end else begin
            nxt.right_cnt = 16'd0;
          end
        end
      end
      MODE_RETURN: begin
        drive         = DRV_REV;
        tick          = inc8(nxt.man_timer);
        nxt.man_timer = tick;
        if (tick >= RETURN_TICKS) begin
          drive            = DRV_STOP;
          nxt.man_timer    = 8'd0;
          nxt.safety_timer = 8'd0;
          nxt.mode         = MODE_TAIL;
        end
      end
      MODE_TAIL: begin
        drive         = DRV_TAIL;
        tick          = inc8(nxt.man_timer);
        nxt.man_timer = tick;
        if (tick >= {5'd0, turn_limit(nxt.gap_ticks)}) begin
          drive            = DRV_STOP;
          nxt.turn_done    = tick;
          nxt.safety_timer = 8'd0;
          nxt.mode         = MODE_REVERSE;
        end
      end
      MODE_REVERSE: begin
        drive = DRV_REV;
        if (nxt.safety_timer >= {4'd0, rev_limit}) begin
          drive         = DRV_STOP;
          nxt.man_timer = 8'd0;
          nxt.mode      = MODE_NOSEIN;
        end
        nxt.safety_timer = inc8(nxt.safety_timer);
      end
      MODE_NOSEIN: begin
        drive         = DRV_NOSEIN;
        tick          = inc8(nxt.man_timer);
        nxt.man_timer = tick;
        if (tick >= SHORT_MIN) begin
          drive         = DRV_STOP;
          nxt.man_timer = 8'd0;
          nxt.mode      = MODE_STRAIGHT;
        end
      end
      MODE_STRAIGHT: begin
        drive         = DRV_STRAIGHT;
        tick          = inc8(nxt.man_timer);
        nxt.man_timer = tick;
        if (tick >= straight_lim) begin
          drive            = DRV_STOP;
          nxt.center_steps = 8'd0;
          nxt.mode         = MODE_CENTER;
        end
      end
      MODE_PARKED: begin
        if (req_i.start_pressed) begin
          nxt.mode = MODE_WAIT;
        end
      end
      MODE_OBSTACLE: begin
        if (req_i.front_cm > cfg_i.front_min_cm) begin
          nxt.mode = MODE_WAIT;
        end
      end
      MODE_CENTER: begin
        steps = inc8(nxt.center_steps);
        if ((req_i.front_cm == 10'd0) || (req_i.rear_cm == 10'd0)) begin
          nxt.center_steps = steps;
          if (steps > cfg_i.center_max_steps) begin
            nxt.mode = MODE_PARKED;
          end
        end else if ((err_f <= tol) && (err_r <= tol)) begin
          nxt.mode = MODE_PARKED;
        end else begin
          nxt.center_steps = steps;
          if (steps > cfg_i.center_max_steps) begin
            nxt.mode = MODE_PARKED;
          end else if ((req_i.front_cm > req_i.rear_cm) &&
                       ({1'b0, req_i.front_cm} > avg_tol)) begin
            if ({1'b0, req_i.front_cm} <= {1'b0, cfg_i.front_min_cm} + {1'b0, tol}) begin
              nxt.mode = MODE_PARKED;
            end else begin
              drive = DRV_FWDPULSE;
            end
          end else if ((req_i.rear_cm > req_i.front_cm) &&
                       ({1'b0, req_i.rear_cm} > avg_tol)) begin
            if ({1'b0, req_i.rear_cm} <= {1'b0, cfg_i.rear_min_cm} + {1'b0, tol}) begin
              nxt.mode = MODE_PARKED;
            end else begin
              drive = DRV_REVPULSE;
            end
          end
        end
      end
      default: begin
        nxt.mode = MODE_WAIT;
      end
    endcase
  end

  assign state_o          = nxt;
  assign res_o.mode       = nxt.mode;
  assign res_o.drive      = drive;
  assign res_o.side_right = nxt.side;
  assign res_o.gap_len    = nxt.gap_ticks;

endmodule

>>> sv/parking_maneuver_sequencer.sv
// Parking maneuver sequencer top level: request register, step logic, result register.
// Depends on pms_pkg and pms_step.
// A request waits in the request register while stalled, then the result is registered.
// One request per cycle unless the output stalls, set by the step logic and state update.
// Reset: rst_ni clears both valid flags, the sequencer state and loads the default
// configuration values; there is no clearing pass.
module parking_maneuver_sequencer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pms_pkg::pms_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pms_pkg::pms_res_t                   out_res_o,
  input  logic                                cfg_we_i,
  input  logic [pms_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pms_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import pms_pkg::*;

  logic       in_valid_q;
  pms_req_t   in_req_q;
  logic       out_valid_q;
  pms_res_t   out_res_q;
  pms_res_t   step_res;
  pms_state_t state_q;
  pms_state_t state_d;
  pms_cfg_t   cfg_q;
  logic       fire;

  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  pms_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .req_i   (in_req_q),
    .state_o (state_d),
    .res_o   (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
    if (fire) begin
      out_res_q <= step_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_min_cm     <= 10'd15;
      cfg_q.rear_min_cm      <= 10'd19;
      cfg_q.gap_cm           <= 10'd25;
      cfg_q.gap_min_ticks    <= 8'd3;
      cfg_q.center_tol_cm    <= 6'd2;
      cfg_q.center_max_steps <= 8'd35;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRONT_MIN:  cfg_q.front_min_cm     <= cfg_wdata_i;
        REG_REAR_MIN:   cfg_q.rear_min_cm      <= cfg_wdata_i;
        REG_GAP_CM:     cfg_q.gap_cm           <= cfg_wdata_i;
        REG_GAP_MIN:    cfg_q.gap_min_ticks    <= cfg_wdata_i[7:0];
        REG_CENTER_TOL: cfg_q.center_tol_cm    <= cfg_wdata_i[5:0];
        REG_CENTER_MAX: cfg_q.center_max_steps <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with an empty request register");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed request produced no result");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(state_q))
    else $error("sequencer state changed without a processed request");

  a_idle_modes_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_res_q.mode == MODE_WAIT) || (out_res_q.mode == MODE_PARKED)))
      |-> (out_res_q.drive == DRV_STOP))
    else $error("drive active in wait or parked mode");
`endif

endmodule

>>> sim/parking_maneuver_sequencer_tb.sv
// Self-checking testbench for parking_maneuver_sequencer: directed maneuvers, counter
// saturation and shaped random sensor traffic under several register settings.
// Depends on pms_pkg and the sequencer RTL only.
`timescale 1ns / 100ps

module parking_maneuver_sequencer_tb;
  import pms_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  pms_req_t              in_req_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  pms_res_t              out_res_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  parking_maneuver_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pms_cfg_t    cfg_m;
  logic [3:0]  cur_mode;
  int unsigned left_run, right_run, gap_length, lateral_dist;
  int unsigned man_timer, safe_timer, turn_done, center_cnt;
  bit          side_right;

  pms_res_t    pending[$];
  int unsigned mismatches;
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned settings_applied;
  int unsigned left_plan, right_plan;
  bit          calm_mode;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("parking_maneuver_sequencer: mismatch");
    $finish;
  end

  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 20);
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      if (!calm_mode) begin
        n = $urandom_range(1, 14);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= !calm_mode;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    pms_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: %p", out_res_o);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (out_res_o.mode !== want.mode) begin
          $error("mode expected %0d got %0d", want.mode, out_res_o.mode);
          mismatches++;
        end
        if (out_res_o.drive !== want.drive) begin
          $error("drive expected %0d got %0d", want.drive, out_res_o.drive);
          mismatches++;
        end
        if (out_res_o.side_right !== want.side_right) begin
          $error("side_right expected %0d got %0d", want.side_right, out_res_o.side_right);
          mismatches++;
        end
        if (out_res_o.gap_len !== want.gap_len) begin
          $error("gap_len expected %0d got %0d", want.gap_len, out_res_o.gap_len);
          mismatches++;
        end
      end
    end
  end

  function automatic int unsigned sat8(int unsigned v);
    return (v < 255) ? v + 1 : 255;
  endfunction

  function automatic int unsigned sat16(int unsigned v);
    return (v < 65535) ? v + 1 : 65535;
  endfunction

  function automatic int unsigned turn_limit(int unsigned g);
    int unsigned t;
    t = g / 2;
    if (t > TURN_MAX) t = TURN_MAX;
    if (t < TURN_MIN) t = TURN_MIN;
    return t;
  endfunction

  task automatic scan_side(input int unsigned d, inout int unsigned run, input bit is_right,
                           inout logic [2:0] drv, output bit took);
    took = 1'b0;
    if (d > cfg_m.gap_cm || d == 0) begin
      run = sat16(run);
    end else if (run > cfg_m.gap_min_ticks) begin
      side_right   = is_right;
      drv          = DRV_STOP;
      gap_length   = run;
      lateral_dist = d;
      man_timer    = 0;
      safe_timer   = 0;
      cur_mode     = MODE_RETURN;
      took         = 1'b1;
    end else begin
      run = 0;
    end
  endtask

  task automatic predict_tick(input pms_req_t r);
    int unsigned frt, rer, avg, ef, ea, lim, tol, extra;
    logic [2:0]  drv;
    bit          took;
    pms_res_t    res;
    frt = r.front_cm;
    rer = r.rear_cm;
    tol = cfg_m.center_tol_cm;
    drv = DRV_STOP;
    if (r.reset_pressed) begin
      cur_mode   = MODE_WAIT;
      left_run   = 0;
      right_run  = 0;
      safe_timer = 0;
    end
    case (cur_mode)
      MODE_WAIT: begin
        if (r.start_pressed) begin
          left_run  = 0;
          right_run = 0;
          cur_mode  = MODE_SEARCH;
        end
      end
      MODE_SEARCH: begin
        drv = DRV_FWD;
        if (frt > 0 && frt < cfg_m.front_min_cm) cur_mode = MODE_OBSTACLE;
        scan_side(r.left_cm, left_run, 1'b0, drv, took);
        if (!took) scan_side(r.right_cm, right_run, 1'b1, drv, took);
      end
      MODE_RETURN: begin
        drv = DRV_REV;
        man_timer = sat8(man_timer);
        if (man_timer >= RETURN_TICKS) begin
          drv        = DRV_STOP;
          man_timer  = 0;
          safe_timer = 0;
          cur_mode   = MODE_TAIL;
        end
      end
      MODE_TAIL: begin
        drv = DRV_TAIL;
        man_timer = sat8(man_timer);
        if (man_timer >= turn_limit(gap_length)) begin
          drv        = DRV_STOP;
          turn_done  = man_timer;
          safe_timer = 0;
          cur_mode   = MODE_REVERSE;
        end
      end
      MODE_REVERSE: begin
        lim = turn_limit(gap_length);
        drv = DRV_REV;
        if (lateral_dist > LATERAL_BASE) begin
          extra = (lateral_dist - LATERAL_BASE) / 2;
          if (extra > EXTRA_MAX) extra = EXTRA_MAX;
          lim += extra;
        end
        if (safe_timer >= lim) begin
          drv       = DRV_STOP;
          man_timer = 0;
          cur_mode  = MODE_NOSEIN;
        end
        safe_timer = sat8(safe_timer);
      end
      MODE_NOSEIN: begin
        drv = DRV_NOSEIN;
        man_timer = sat8(man_timer);
        if (man_timer >= SHORT_MIN) begin
          drv       = DRV_STOP;
          man_timer = 0;
          cur_mode  = MODE_STRAIGHT;
        end
      end
      MODE_STRAIGHT: begin
        lim = (turn_done >= SHORT_MIN + 2) ? turn_done - 2 : SHORT_MIN;
        drv = DRV_STRAIGHT;
        man_timer = sat8(man_timer);
        if (man_timer >= lim) begin
          drv        = DRV_STOP;
          center_cnt = 0;
          cur_mode   = MODE_CENTER;
        end
      end
      MODE_PARKED: begin
        if (r.start_pressed) cur_mode = MODE_WAIT;
      end
      MODE_OBSTACLE: begin
        if (frt > cfg_m.front_min_cm) cur_mode = MODE_WAIT;
      end
      MODE_CENTER: begin
        if (frt == 0 || rer == 0) begin
          center_cnt = sat8(center_cnt);
          if (center_cnt > cfg_m.center_max_steps) cur_mode = MODE_PARKED;
        end else begin
          avg = (frt + rer) / 2;
          ef  = (frt > avg) ? frt - avg : avg - frt;
          ea  = (rer > avg) ? rer - avg : avg - rer;
          if (ef <= tol && ea <= tol) begin
            cur_mode = MODE_PARKED;
          end else begin
            center_cnt = sat8(center_cnt);
            if (center_cnt > cfg_m.center_max_steps) begin
              cur_mode = MODE_PARKED;
            end else if (frt > rer && frt > avg + tol) begin
              if (frt <= cfg_m.front_min_cm + tol) cur_mode = MODE_PARKED;
              else drv = DRV_FWDPULSE;
            end else if (rer > frt && rer > avg + tol) begin
              if (rer <= cfg_m.rear_min_cm + tol) cur_mode = MODE_PARKED;
              else drv = DRV_REVPULSE;
            end
          end
        end
      end
      default: begin
        cur_mode = MODE_WAIT;
      end
    endcase
    res.mode       = cur_mode;
    res.drive      = drv;
    res.side_right = side_right;
    res.gap_len    = gap_length[15:0];
    pending.push_back(res);
  endtask

  function automatic pms_req_t make_tick(int unsigned l, int unsigned r, int unsigned f,
                                         int unsigned b, bit st, bit rs);
    pms_req_t t;
    t.left_cm       = 10'(l);
    t.right_cm      = 10'(r);
    t.front_cm      = 10'(f);
    t.rear_cm       = 10'(b);
    t.start_pressed = st;
    t.reset_pressed = rs;
    return t;
  endfunction

  task automatic send_tick(input pms_req_t r);
    if (!calm_mode && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_tick(r);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_FRONT_MIN:  cfg_m.front_min_cm     = val;
      REG_REAR_MIN:   cfg_m.rear_min_cm      = val;
      REG_GAP_CM:     cfg_m.gap_cm           = val;
      REG_GAP_MIN:    cfg_m.gap_min_ticks    = val[7:0];
      REG_CENTER_TOL: cfg_m.center_tol_cm    = val[5:0];
      REG_CENTER_MAX: cfg_m.center_max_steps = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_config(input int unsigned fmin, input int unsigned rmin,
                              input int unsigned gcm, input int unsigned gmin,
                              input int unsigned tol, input int unsigned cmax);
    drain_results();
    write_reg(REG_FRONT_MIN, 10'(fmin));
    write_reg(REG_REAR_MIN, 10'(rmin));
    write_reg(REG_GAP_CM, 10'(gcm));
    write_reg(REG_GAP_MIN, 10'(gmin));
    write_reg(REG_CENTER_TOL, 10'(tol));
    write_reg(REG_CENTER_MAX, 10'(cmax));
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  // Returns a side reading that follows a planned run of gap ticks ended by a near echo.
  function automatic logic [9:0] side_reading(inout int unsigned plan);
    int unsigned g;
    g = cfg_m.gap_cm;
    if (plan > 0) begin
      plan--;
      if (g == 1023 || $urandom_range(0, 5) == 0) return '0;
      return 10'($urandom_range(g + 1, 1023));
    end
    plan = $urandom_range(0, cfg_m.gap_min_ticks + 4);
    if (g == 0) return 10'($urandom_range(1, 1023));
    return 10'($urandom_range(1, g));
  endfunction

  function automatic pms_req_t random_tick();
    pms_req_t r;
    int       spread, base, other;
    int unsigned fmin;
    fmin = cfg_m.front_min_cm;
    r.left_cm       = 10'($urandom);
    r.right_cm      = 10'($urandom);
    r.front_cm      = 10'($urandom);
    r.rear_cm       = 10'($urandom);
    r.start_pressed = ($urandom_range(0, 4) == 0);
    r.reset_pressed = ($urandom_range(0, 49) == 0);
    if ($urandom_range(0, 11) == 0) begin
      r.reset_pressed = 1'($urandom_range(0, 1));
      return r;
    end
    case (cur_mode)
      MODE_WAIT: r.start_pressed = ($urandom_range(0, 3) != 0);
      MODE_SEARCH: begin
        r.left_cm  = side_reading(left_plan);
        r.right_cm = side_reading(right_plan);
        if ($urandom_range(0, 6) == 0) r.front_cm = 10'($urandom_range(0, fmin));
        else if ($urandom_range(0, 9) == 0) r.front_cm = '0;
        else r.front_cm = 10'($urandom_range(fmin, 1023));
        r.start_pressed = ($urandom_range(0, 9) == 0);
      end
      MODE_OBSTACLE: begin
        if ($urandom_range(0, 2) == 0) r.front_cm = '0;
      end
      MODE_PARKED: r.start_pressed = ($urandom_range(0, 2) == 0);
      MODE_CENTER: begin
        if ($urandom_range(0, 4) != 0) begin
          spread = int'(cfg_m.center_tol_cm) + 4;
          base   = $urandom_range(0, 1023);
          other  = base + int'($urandom_range(0, 2 * spread)) - spread;
          if (other < 0) other = 0;
          if (other > 1023) other = 1023;
          if ($urandom_range(0, 1) == 0) begin
            r.front_cm = 10'(base);
            r.rear_cm  = 10'(other);
          end else begin
            r.front_cm = 10'(other);
            r.rear_cm  = 10'(base);
          end
          if ($urandom_range(0, 6) == 0) r.front_cm = '0;
          else if ($urandom_range(0, 6) == 0) r.rear_cm = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic test_search_and_accept();
    send_tick(make_tick(0, 0, 0, 0, 1'b0, 1'b0));
    send_tick(make_tick(1023, 1023, 1023, 1023, 1'b1, 1'b1));
    repeat (4) send_tick(make_tick(0, 1023, 1023, 1023, 1'b0, 1'b0));
    // Obstacle and an accepted gap in the same tick: the gap wins.
    send_tick(make_tick(10, 1023, 5, 0, 1'b0, 1'b0));
  endtask

  task automatic test_full_maneuver();
    for (int k = 0; k < 40 && cur_mode != MODE_CENTER; k++) begin
      send_tick(make_tick(1023, 1023, 1023, 1023, 1'b0, 1'b0));
    end
    send_tick(make_tick(0, 0, 0, 40, 1'b0, 1'b0));
    send_tick(make_tick(0, 0, 100, 60, 1'b0, 1'b0));
    send_tick(make_tick(0, 0, 30, 70, 1'b0, 1'b0));
    send_tick(make_tick(0, 0, 40, 41, 1'b0, 1'b0));
    send_tick(make_tick(0, 0, 0, 0, 1'b1, 1'b0));
  endtask

  task automatic test_obstacle_hold();
    send_tick(make_tick(0, 0, 0, 0, 1'b1, 1'b0));
    send_tick(make_tick(10, 10, 5, 0, 1'b0, 1'b0));
    send_tick(make_tick(10, 10, 0, 0, 1'b0, 1'b0));
    send_tick(make_tick(10, 10, 15, 0, 1'b0, 1'b0));
    send_tick(make_tick(10, 10, 16, 0, 1'b0, 1'b0));
  endtask

  task automatic test_side_priority();
    send_tick(make_tick(0, 0, 0, 0, 1'b1, 1'b0));
    repeat (5) send_tick(make_tick(10, 0, 1023, 0, 1'b0, 1'b0));
    send_tick(make_tick(10, 10, 1023, 0, 1'b0, 1'b0));
    send_tick(make_tick(0, 0, 0, 0, 1'b0, 1'b1));
    send_tick(make_tick(0, 0, 0, 0, 1'b1, 1'b0));
    repeat (5) send_tick(make_tick(0, 0, 1023, 0, 1'b0, 1'b0));
    send_tick(make_tick(10, 10, 1023, 0, 1'b0, 1'b0));
    send_tick(make_tick(0, 0, 0, 0, 1'b1, 1'b1));
    send_tick(make_tick(0, 0, 0, 0, 1'b0, 1'b1));
  endtask

  task automatic test_counter_saturation();
    calm_mode = 1'b1;
    send_tick(make_tick(0, 0, 0, 0, 1'b1, 1'b0));
    repeat (40) send_tick(make_tick(0, 0, 1023, 1023, 1'b0, 1'b0));
    send_tick(make_tick(1023, 20, 1023, 1023, 1'b0, 1'b0));
    for (int k = 0; k < 40 && cur_mode != MODE_CENTER; k++) begin
      send_tick(make_tick(1023, 1023, 1023, 1023, 1'b0, 1'b0));
    end
    drain_results();
    write_reg(REG_CENTER_MAX, 10'd255);
    cfg_we_i <= 1'b0;
    repeat (260) send_tick(make_tick(0, 0, 500, 0, 1'b0, 1'b0));
    send_tick(make_tick(0, 0, 0, 0, 1'b0, 1'b1));
    calm_mode = 1'b0;
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit hold_midway);
    left_plan  = 0;
    right_plan = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (hold_midway && i == count / 2) drain_results();
      send_tick(random_tick());
    end
  endtask

  initial begin
    cfg_m = '{front_min_cm: 10'd15, rear_min_cm: 10'd19, gap_cm: 10'd25,
              gap_min_ticks: 8'd3, center_tol_cm: 6'd2, center_max_steps: 8'd35};
    cur_mode     = MODE_WAIT;
    left_run     = 0;
    right_run    = 0;
    gap_length   = 0;
    lateral_dist = 0;
    man_timer    = 0;
    safe_timer   = 0;
    turn_done    = 0;
    center_cnt   = 0;
    side_right   = 1'b0;
    mismatches   = 0;
    calm_mode    = 1'b0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_FRONT_MIN;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_search_and_accept();
    test_full_maneuver();
    test_obstacle_hold();
    test_side_priority();
    test_counter_saturation();

    apply_config(15, 19, 25, 3, 2, 35);
    test_random_traffic(200, 1'b0);
    apply_config(0, 0, 1023, 0, 0, 0);
    test_random_traffic(200, 1'b1);
    apply_config(1023, 1023, 0, 255, 63, 255);
    test_random_traffic(200, 1'b0);
    apply_config($urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(10, 200),
                 $urandom_range(0, 8), $urandom_range(0, 10), $urandom_range(0, 40));
    test_random_traffic(200, 1'b0);
    apply_config($urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(10, 200),
                 $urandom_range(0, 8), $urandom_range(0, 10), $urandom_range(0, 40));
    test_random_traffic(200, 1'b0);
    apply_config(15, 19, 25, 3, 2, 35);
    calm_mode = 1'b1;
    test_random_traffic(200, 1'b0);

    in_valid_i <= 1'b0;
    for (int k = 0; k < 5000 && pending.size() != 0; k++) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    if (pending.size() != 0) begin
      $error("%0d results never arrived", pending.size());
      mismatches++;
    end

    $display("Covered %0d sensor ticks under %0d register settings, with full maneuvers,",
             ticks_sent, settings_applied);
    $display("obstacle holds, side priority and counter saturation; %0d results checked.",
             results_seen);
    if (mismatches == 0) begin
      $display("parking_maneuver_sequencer: match");
    end else begin
      $display("parking_maneuver_sequencer: mismatch");
    end
    $finish;
  end

endmodule
